@@ hdl/ffha_pkg.sv @@
// Shared types and constants for the first-fit heap allocator.
package ffha_pkg;

    localparam int DESCRIPTORS = 64;
    localparam int IW = $clog2(DESCRIPTORS);
    localparam int ADDR_W = 24;
    localparam int SIZE_W = 25;
    localparam logic [SIZE_W-1:0] ADDR_SPACE = 25'h1000000;

    typedef enum logic [1:0] {
        STAT_OK = 2'd0,
        STAT_NO_PAGES = 2'd1,
        STAT_TABLE_FULL = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        CFG_MIN_SPLIT = 1'b0,
        CFG_PAGE_LIMIT = 1'b1
    } cfg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_TAIL, S_CHECK,
        S_W_IDX, S_W_TLINK, S_W_REST, S_W_NLINK,
        S_F_MARK, S_F_RDP, S_F_MP, S_F_MPL, S_F_MPK,
        S_F_NX, S_F_RDN, S_F_MN, S_F_MNL, S_F_MNK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              en;
        logic [IW-1:0]     idx;
        logic              we_start;
        logic              we_size;
        logic              we_prev;
        logic              we_next;
        logic              we_free;
        logic              we_valid;
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic [IW-1:0]     prev;
        logic [IW-1:0]     next;
        logic              free;
        logic              valid;
    } wr_t;

    typedef struct packed {
        logic              op_free;
        logic [SIZE_W-1:0] n;
        logic [ADDR_W-1:0] addr;
    } key_t;

    typedef struct packed {
        logic              hit;
        logic [IW-1:0]     hidx;
        logic [ADDR_W-1:0] hstart;
        logic [SIZE_W-1:0] hsize;
        logic [IW-1:0]     hprev;
        logic [IW-1:0]     hnext;
        logic              a_ok;
        logic [IW-1:0]     a;
        logic              b_ok;
        logic [IW-1:0]     b;
    } scan_t;

    typedef struct packed {
        logic              valid;
        logic              free;
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic [IW-1:0]     prev;
        logic [IW-1:0]     next;
    } view_t;

endpackage

@@ hdl/ffha_cell.sv @@
// One descriptor cell: holds a chunk descriptor and forwards the search result to its neighbour.
module ffha_cell #(
    parameter int ID = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ffha_pkg::wr_t   wr,
    input  ffha_pkg::key_t  key,
    input  ffha_pkg::scan_t carry_in,
    output ffha_pkg::scan_t carry_out,
    output ffha_pkg::view_t view
);
    import ffha_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(ID);

    logic [ADDR_W-1:0] start_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [IW-1:0]     prev_reg;
    logic [IW-1:0]     next_reg;
    logic              free_reg;
    logic              valid_reg;
    scan_t             carry_reg;
    scan_t             carry_next;
    logic              sel;
    logic              match;

    assign sel = wr.en && (wr.idx == MY_IDX);

    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            if (wr.we_start) start_reg <= wr.start;
            if (wr.we_size)  size_reg  <= wr.size;
            if (wr.we_prev)  prev_reg  <= wr.prev;
            if (wr.we_next)  next_reg  <= wr.next;
            if (wr.we_free)  free_reg  <= wr.free;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            carry_reg <= '0;
        end
        else
        begin
            if (sel && wr.we_valid) valid_reg <= wr.valid;
            carry_reg <= carry_next;
        end
    end

    always_comb
    begin
        if (key.op_free)
            match = valid_reg && (start_reg == key.addr);
        else
            match = valid_reg && free_reg && (size_reg >= key.n);
        carry_next = carry_in;
        if (!carry_in.hit && match)
        begin
            carry_next.hit    = 1'b1;
            carry_next.hidx   = MY_IDX;
            carry_next.hstart = start_reg;
            carry_next.hsize  = size_reg;
            carry_next.hprev  = prev_reg;
            carry_next.hnext  = next_reg;
        end
        if (!valid_reg)
        begin
            if (!carry_in.a_ok)
            begin
                carry_next.a_ok = 1'b1;
                carry_next.a    = MY_IDX;
            end
            else if (!carry_in.b_ok)
            begin
                carry_next.b_ok = 1'b1;
                carry_next.b    = MY_IDX;
            end
        end
    end

    assign carry_out = carry_reg;
    assign view = '{valid: valid_reg, free: free_reg, start: start_reg, size: size_reg,
                    prev: prev_reg, next: next_reg};

endmodule

@@ hdl/first_fit_heap_allocator.sv @@
// Top level of the first-fit heap allocator: sequencer, registers and the row of descriptor cells.
//
// Channel  Direction  Handshake                      Content
// s_axis   in         s_axis_tvalid/s_axis_tready    one allocate or free request
// m_axis   out        m_axis_tvalid/m_axis_tready    block address and status
// cfg      in         cfg_valid/cfg_ready            register index and write data
//
// Every request ripples through the chain of 64 descriptor cells, then passes through
// decision, reads and writes on the descriptor row, and finally loads the result register.
// One request is in work at a time; the next is taken once the result register is loaded.
// Reset clears the valid bits at once; no clearing pass runs.
// A stalled result only holds the block once the following result is ready.
module first_fit_heap_allocator #(
    parameter int PAGE_BYTES = 4096,
    parameter int HEAP_PAGES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // request_bytes[24:0], free_address[48:25], zeros
    input  logic        s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // block_address[23:0], status[25:24], zeros
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import ffha_pkg::*;

    localparam int PB_SH = $clog2(PAGE_BYTES);
    localparam logic [25:0] PB_MASK = 26'(PAGE_BYTES - 1);
    localparam logic [16:0] HEAP_LIM = 17'(HEAP_PAGES);

    state_t            state_reg, state_next;
    logic [IW-1:0]     cnt_reg, cnt_next;
    key_t              key_reg, key_next;
    scan_t             sc_reg, sc_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [ADDR_W-1:0] istart_reg, istart_next;
    logic [IW-1:0]     inext_reg, inext_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [25:0]       got_reg, got_next;
    logic              append_reg, append_next;
    logic              tv_reg, tv_next;
    logic [IW-1:0]     told_reg, told_next;
    logic              split_reg, split_next;
    logic [IW-1:0]     rest_reg, rest_next;
    logic [IW-1:0]     p_reg, p_next;
    logic [SIZE_W-1:0] psize_reg, psize_next;
    logic [IW-1:0]     nx_reg, nx_next;
    logic [SIZE_W-1:0] nsize_reg, nsize_next;
    logic [IW-1:0]     nnext_reg, nnext_next;
    logic [IW-1:0]     tail_reg, tail_next;
    logic [SIZE_W-1:0] mtop_reg, mtop_next;
    logic [15:0]       msplit_reg;
    logic [12:0]       plimit_reg;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    status_t           res_stat_reg, res_stat_next;
    logic              mvalid_reg, mvalid_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    status_t           out_stat_reg, out_stat_next;

    wr_t               wr;
    scan_t             chain [0:DESCRIPTORS];
    view_t             views [DESCRIPTORS];
    logic [DESCRIPTORS-1:0] valid_vec;
    logic [IW-1:0]     rd_idx;
    view_t             rd;

    logic [25:0]       req_round;
    logic [16:0]       lim_pages;
    logic [33:0]       lim;
    logic              oom;
    logic              ext;
    logic              full;
    logic              split_c;

    assign chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < DESCRIPTORS; gi++)
        begin : g_cell
            ffha_cell #(.ID(gi)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .wr        (wr),
                .key       (key_reg),
                .carry_in  (chain[gi]),
                .carry_out (chain[gi+1]),
                .view      (views[gi])
            );
            assign valid_vec[gi] = views[gi].valid;
        end
    endgenerate

    assign rd = views[rd_idx];

    assign cfg_ready = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata = {6'd0, out_stat_reg, out_addr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            tail_reg   <= '0;
            mtop_reg   <= '0;
            msplit_reg <= 16'd64;
            plimit_reg <= 13'd4096;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            tail_reg   <= tail_next;
            mtop_reg   <= mtop_next;
            mvalid_reg <= mvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_MIN_SPLIT:  msplit_reg <= cfg_data;
                    CFG_PAGE_LIMIT: plimit_reg <= cfg_data[12:0];
                    default:        msplit_reg <= msplit_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        key_reg      <= key_next;
        sc_reg       <= sc_next;
        idx_reg      <= idx_next;
        istart_reg   <= istart_next;
        inext_reg    <= inext_next;
        size_reg     <= size_next;
        got_reg      <= got_next;
        append_reg   <= append_next;
        tv_reg       <= tv_next;
        told_reg     <= told_next;
        split_reg    <= split_next;
        rest_reg     <= rest_next;
        p_reg        <= p_next;
        psize_reg    <= psize_next;
        nx_reg       <= nx_next;
        nsize_reg    <= nsize_next;
        nnext_reg    <= nnext_next;
        res_addr_reg <= res_addr_next;
        res_stat_reg <= res_stat_next;
        out_addr_reg <= out_addr_next;
        out_stat_reg <= out_stat_next;
    end

    always_comb
    begin
        req_round = (26'(key_reg.n) + PB_MASK) & ~PB_MASK;
        lim_pages = (17'(plimit_reg) < HEAP_LIM) ? 17'(plimit_reg) : HEAP_LIM;
        lim = 34'(lim_pages) << PB_SH;
        if (lim > 34'(ADDR_SPACE))
            lim = 34'(ADDR_SPACE);
        oom = (34'(mtop_reg) + 34'(req_round)) > lim;
        ext = rd.valid && rd.free && ((26'(rd.start) + 26'(rd.size)) == 26'(mtop_reg));
        split_c = (size_reg - key_reg.n) > 25'(msplit_reg);
        full = ((append_reg || split_c) && !sc_reg.a_ok) ||
               (append_reg && split_c && !sc_reg.b_ok);
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        key_next      = key_reg;
        sc_next       = sc_reg;
        idx_next      = idx_reg;
        istart_next   = istart_reg;
        inext_next    = inext_reg;
        size_next     = size_reg;
        got_next      = got_reg;
        append_next   = append_reg;
        tv_next       = tv_reg;
        told_next     = told_reg;
        split_next    = split_reg;
        rest_next     = rest_reg;
        p_next        = p_reg;
        psize_next    = psize_reg;
        nx_next       = nx_reg;
        nsize_next    = nsize_reg;
        nnext_next    = nnext_reg;
        tail_next     = tail_reg;
        mtop_next     = mtop_reg;
        res_addr_next = res_addr_reg;
        res_stat_next = res_stat_reg;
        out_addr_next = out_addr_reg;
        out_stat_next = out_stat_reg;
        mvalid_next   = mvalid_reg && !m_axis_tready;
        wr            = '0;
        rd_idx        = tail_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    key_next.op_free = s_axis_tuser;
                    key_next.n = (s_axis_tdata[24:0] == '0) ? 25'd1 : s_axis_tdata[24:0];
                    key_next.addr = s_axis_tdata[48:25];
                    cnt_next = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IW'(DESCRIPTORS - 1))
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                sc_next = chain[DESCRIPTORS];
                res_addr_next = '0;
                if (key_reg.op_free)
                begin
                    if (!chain[DESCRIPTORS].hit)
                    begin
                        res_stat_next = STAT_NOT_FOUND;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next = chain[DESCRIPTORS].hidx;
                        size_next = chain[DESCRIPTORS].hsize;
                        inext_next = chain[DESCRIPTORS].hnext;
                        res_stat_next = STAT_OK;
                        state_next = S_F_MARK;
                    end
                end
                else if (chain[DESCRIPTORS].hit)
                begin
                    idx_next = chain[DESCRIPTORS].hidx;
                    istart_next = chain[DESCRIPTORS].hstart;
                    inext_next = chain[DESCRIPTORS].hnext;
                    size_next = chain[DESCRIPTORS].hsize;
                    append_next = 1'b0;
                    state_next = S_CHECK;
                end
                else
                begin
                    got_next = req_round;
                    if (oom)
                    begin
                        res_stat_next = STAT_NO_PAGES;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                rd_idx = tail_reg;
                tv_next = rd.valid;
                told_next = tail_reg;
                if (ext)
                begin
                    idx_next = tail_reg;
                    istart_next = rd.start;
                    inext_next = rd.next;
                    size_next = 25'(rd.size + 25'(got_reg));
                    append_next = 1'b0;
                end
                else
                begin
                    idx_next = sc_reg.a;
                    istart_next = mtop_reg[ADDR_W-1:0];
                    inext_next = sc_reg.a;
                    size_next = 25'(got_reg);
                    append_next = 1'b1;
                end
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                split_next = split_c;
                rest_next = append_reg ? sc_reg.b : sc_reg.a;
                if (full)
                begin
                    res_addr_next = '0;
                    res_stat_next = STAT_TABLE_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    res_addr_next = istart_reg;
                    res_stat_next = STAT_OK;
                    state_next = S_W_IDX;
                end
            end
            S_W_IDX:
            begin
                wr.en = 1'b1;
                wr.idx = idx_reg;
                wr.we_size = 1'b1;
                wr.size = split_reg ? key_reg.n : size_reg;
                wr.we_free = 1'b1;
                wr.free = 1'b0;
                wr.we_next = split_reg || append_reg;
                wr.next = split_reg ? rest_reg : idx_reg;
                if (append_reg)
                begin
                    wr.we_start = 1'b1;
                    wr.start = istart_reg;
                    wr.we_prev = 1'b1;
                    wr.prev = tv_reg ? told_reg : idx_reg;
                    wr.we_valid = 1'b1;
                    wr.valid = 1'b1;
                    tail_next = idx_reg;
                end
                if (!sc_reg.hit)
                    mtop_next = 25'(mtop_reg + 25'(got_reg));
                if (append_reg && tv_reg)
                    state_next = S_W_TLINK;
                else if (split_reg)
                    state_next = S_W_REST;
                else
                    state_next = S_DONE;
            end
            S_W_TLINK:
            begin
                wr.en = 1'b1;
                wr.idx = told_reg;
                wr.we_next = 1'b1;
                wr.next = idx_reg;
                state_next = split_reg ? S_W_REST : S_DONE;
            end
            S_W_REST:
            begin
                wr.en = 1'b1;
                wr.idx = rest_reg;
                wr.we_start = 1'b1;
                wr.start = 24'(25'(istart_reg) + key_reg.n);
                wr.we_size = 1'b1;
                wr.size = size_reg - key_reg.n;
                wr.we_prev = 1'b1;
                wr.prev = idx_reg;
                wr.we_next = 1'b1;
                wr.next = (inext_reg == idx_reg) ? rest_reg : inext_reg;
                wr.we_valid = 1'b1;
                wr.valid = 1'b1;
                wr.we_free = 1'b1;
                wr.free = 1'b1;
                if (tail_reg == idx_reg)
                    tail_next = rest_reg;
                state_next = (inext_reg != idx_reg) ? S_W_NLINK : S_DONE;
            end
            S_W_NLINK:
            begin
                wr.en = 1'b1;
                wr.idx = inext_reg;
                wr.we_prev = 1'b1;
                wr.prev = rest_reg;
                state_next = S_DONE;
            end
            S_F_MARK:
            begin
                wr.en = 1'b1;
                wr.idx = idx_reg;
                wr.we_free = 1'b1;
                wr.free = 1'b1;
                state_next = (sc_reg.hprev != idx_reg) ? S_F_RDP : S_F_NX;
            end
            S_F_RDP:
            begin
                rd_idx = sc_reg.hprev;
                p_next = sc_reg.hprev;
                psize_next = rd.size;
                state_next = rd.free ? S_F_MP : S_F_NX;
            end
            S_F_MP:
            begin
                wr.en = 1'b1;
                wr.idx = p_reg;
                wr.we_size = 1'b1;
                wr.size = psize_reg + size_reg;
                wr.we_next = 1'b1;
                wr.next = (inext_reg == idx_reg) ? p_reg : inext_reg;
                if (tail_reg == idx_reg)
                    tail_next = p_reg;
                state_next = (inext_reg != idx_reg) ? S_F_MPL : S_F_MPK;
            end
            S_F_MPL:
            begin
                wr.en = 1'b1;
                wr.idx = inext_reg;
                wr.we_prev = 1'b1;
                wr.prev = p_reg;
                state_next = S_F_MPK;
            end
            S_F_MPK:
            begin
                wr.en = 1'b1;
                wr.idx = idx_reg;
                wr.we_valid = 1'b1;
                wr.valid = 1'b0;
                wr.we_free = 1'b1;
                wr.free = 1'b0;
                idx_next = p_reg;
                size_next = psize_reg + size_reg;
                inext_next = (inext_reg == idx_reg) ? p_reg : inext_reg;
                state_next = S_F_NX;
            end
            S_F_NX:
            begin
                state_next = (inext_reg != idx_reg) ? S_F_RDN : S_DONE;
            end
            S_F_RDN:
            begin
                rd_idx = inext_reg;
                nx_next = inext_reg;
                nsize_next = rd.size;
                nnext_next = rd.next;
                state_next = rd.free ? S_F_MN : S_DONE;
            end
            S_F_MN:
            begin
                wr.en = 1'b1;
                wr.idx = idx_reg;
                wr.we_size = 1'b1;
                wr.size = size_reg + nsize_reg;
                wr.we_next = 1'b1;
                wr.next = (nnext_reg == nx_reg) ? idx_reg : nnext_reg;
                if (tail_reg == nx_reg)
                    tail_next = idx_reg;
                state_next = (nnext_reg != nx_reg) ? S_F_MNL : S_F_MNK;
            end
            S_F_MNL:
            begin
                wr.en = 1'b1;
                wr.idx = nnext_reg;
                wr.we_prev = 1'b1;
                wr.prev = idx_reg;
                state_next = S_F_MNK;
            end
            S_F_MNK:
            begin
                wr.en = 1'b1;
                wr.idx = nx_reg;
                wr.we_valid = 1'b1;
                wr.valid = 1'b0;
                wr.we_free = 1'b1;
                wr.free = 1'b0;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!mvalid_reg || m_axis_tready)
                begin
                    out_addr_next = res_addr_reg;
                    out_stat_next = res_stat_reg;
                    mvalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_err_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (mvalid_reg && (out_stat_reg != STAT_OK)) |-> (out_addr_reg == '0))
        else $error("error result carries a non-zero address");

    a_tail_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDLE) && (|valid_vec)) |-> valid_vec[tail_reg])
        else $error("tail points at an invalid descriptor");

    a_oom_no_growth: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DECIDE) && !key_reg.op_free && !chain[DESCRIPTORS].hit && oom)
        |=> $stable(mtop_reg))
        else $error("heap grew on an out-of-pages request");

    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mtop_reg <= ADDR_SPACE)
        else $error("mapped top beyond the address space");

endmodule
